// ----- hdl/frtc_pkg.sv -----
`timescale 1ns / 1ps
// Shared definitions for the free-running timer with output compare.
// Command codes, register offsets, bit positions and reset values.
// No dependencies.
package frtc_pkg;

  // Command codes carried by each item
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Byte register offsets
  localparam logic [2:0] ADDR_ENABLE  = 3'd0;
  localparam logic [2:0] ADDR_STATUS  = 3'd1;
  localparam logic [2:0] ADDR_CNT_HI  = 3'd2;
  localparam logic [2:0] ADDR_CNT_LO  = 3'd3;
  localparam logic [2:0] ADDR_CMP_HI  = 3'd4;
  localparam logic [2:0] ADDR_CMP_LO  = 3'd5;
  localparam logic [2:0] ADDR_CONTROL = 3'd6;
  localparam logic [2:0] ADDR_OUT_CTL = 3'd7;

  // Bit positions and reset values
  localparam int          ENABLE_IRQ_BIT  = 3;
  localparam int          STATUS_FLAG_BIT = 3;
  localparam logic [7:0]  ENABLE_RESERVED = 8'h01;
  localparam logic [15:0] COMPARE_RESET   = 16'hffff;

  // Default tick divide ratio
  localparam int PRESCALE_DIV_DEFAULT = 8;

endpackage

// ----- hdl/free_running_timer_compare.sv -----
`timescale 1ns / 1ps
// Free-running 16-bit timer with one output-compare register, byte access.
// An accepted item waits in the input register, then moves into the result register.
// Throughput: one item per cycle while the result side does not stall; the input
// register and the result register part the two sides, so an item is taken while a result waits.
// Reset (rst, synchronous): counter 0, compare 0xffff, flag clear, enable 0x01.
// Depends on frtc_pkg.
module free_running_timer_compare #(
  parameter int PRESCALE_DIV = frtc_pkg::PRESCALE_DIV_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] cmd,
  input  logic [2:0] reg_addr,
  input  logic [7:0] write_data,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] read_data,
  output logic       compare_flag,
  output logic       irq_request
);
  import frtc_pkg::*;

  localparam int PRESCALE_W = (PRESCALE_DIV > 1) ? $clog2(PRESCALE_DIV) : 1;
  localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(PRESCALE_DIV - 1);

  // Input register
  logic       stage_valid;
  logic [1:0] stage_cmd;
  logic [2:0] stage_addr;
  logic [7:0] stage_data;

  // Timer state
  logic [15:0]           counter, counter_next;
  logic [15:0]           compare_value, compare_value_next;
  logic                  match_flag, match_flag_next;
  logic [7:0]            enable_reg, enable_reg_next;
  logic [7:0]            control_reg, control_reg_next;
  logic [7:0]            output_control_reg, output_control_reg_next;
  logic [7:0]            temp_byte, temp_byte_next;
  logic [PRESCALE_W-1:0] prescale_count, prescale_count_next;
  logic [7:0]            read_data_next;

  logic out_ready;
  logic advance;
  logic accept;

  assign out_ready  = !result_valid || !result_stall;
  assign advance    = stage_valid && out_ready;
  assign item_stall = stage_valid && !out_ready;
  assign accept     = item_valid && !item_stall;

  // Hold the item in the input register until the result register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd  <= cmd;
      stage_addr <= reg_addr;
      stage_data <= write_data;
    end
  end

  // Work out the next timer state and the read byte for the staged item
  always_comb begin
    counter_next            = counter;
    compare_value_next      = compare_value;
    match_flag_next         = match_flag;
    enable_reg_next         = enable_reg;
    control_reg_next        = control_reg;
    output_control_reg_next = output_control_reg;
    temp_byte_next          = temp_byte;
    prescale_count_next     = prescale_count;
    read_data_next          = 8'h00;
    case (stage_cmd)
      CMD_TICK: begin
        if (prescale_count == PRESCALE_LAST) begin
          prescale_count_next = '0;
          counter_next        = counter + 16'd1;
          if (counter_next == compare_value) begin
            match_flag_next = 1'b1;
          end
        end else begin
          prescale_count_next = prescale_count + PRESCALE_W'(1);
        end
      end
      CMD_READ: begin
        unique case (stage_addr)
          ADDR_ENABLE:  read_data_next = enable_reg;
          ADDR_STATUS:  read_data_next = {4'h0, match_flag, 3'h0};
          ADDR_CNT_HI: begin
            read_data_next = counter[15:8];
            temp_byte_next = counter[7:0];
          end
          ADDR_CNT_LO:  read_data_next = temp_byte;
          ADDR_CMP_HI:  read_data_next = compare_value[15:8];
          ADDR_CMP_LO:  read_data_next = compare_value[7:0];
          ADDR_CONTROL: read_data_next = control_reg;
          ADDR_OUT_CTL: read_data_next = output_control_reg;
          default:      read_data_next = 8'h00;
        endcase
      end
      CMD_WRITE: begin
        unique case (stage_addr)
          ADDR_ENABLE:  enable_reg_next = stage_data | ENABLE_RESERVED;
          ADDR_STATUS: begin
            // Status writes only ever clear the flag
            if (!stage_data[STATUS_FLAG_BIT]) begin
              match_flag_next = 1'b0;
            end
          end
          ADDR_CNT_HI:  temp_byte_next = stage_data;
          ADDR_CNT_LO:  counter_next = {temp_byte, stage_data};
          ADDR_CMP_HI:  temp_byte_next = stage_data;
          ADDR_CMP_LO:  compare_value_next = {temp_byte, stage_data};
          ADDR_CONTROL: control_reg_next = stage_data;
          ADDR_OUT_CTL: output_control_reg_next = stage_data;
          default:      temp_byte_next = temp_byte;
        endcase
      end
      default: begin
        read_data_next = 8'h00;
      end
    endcase
  end

  // Commit state as the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      counter            <= 16'h0000;
      compare_value      <= COMPARE_RESET;
      match_flag         <= 1'b0;
      enable_reg         <= ENABLE_RESERVED;
      control_reg        <= 8'h00;
      output_control_reg <= 8'h00;
      temp_byte          <= 8'h00;
      prescale_count     <= '0;
    end else if (advance) begin
      counter            <= counter_next;
      compare_value      <= compare_value_next;
      match_flag         <= match_flag_next;
      enable_reg         <= enable_reg_next;
      control_reg        <= control_reg_next;
      output_control_reg <= output_control_reg_next;
      temp_byte          <= temp_byte_next;
      prescale_count     <= prescale_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data    <= read_data_next;
      compare_flag <= match_flag_next;
      irq_request  <= match_flag_next && enable_reg_next[ENABLE_IRQ_BIT];
    end
  end

endmodule

// ----- hdl/frtc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the free-running timer, bound to the top level.
// Depends on free_running_timer_compare.
module frtc_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] read_data,
  input logic       compare_flag,
  input logic       irq_request
);

  // While a result is valid, the interrupt request never shows without the flag
  a_irq_needs_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!irq_request || compare_flag))
    else $error("irq_request without compare_flag");

  // Stalled result keeps its contents
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(read_data) && $stable(compare_flag) && $stable(irq_request)))
    else $error("stalled result changed");

  // Input side backs up only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("item_stall without a waiting result");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result_valid after reset");

endmodule

bind free_running_timer_compare frtc_checker u_frtc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .read_data    (read_data),
  .compare_flag (compare_flag),
  .irq_request  (irq_request)
);
